@@ rtl/svdw_pkg.sv @@
// ---------------------------------------------------------------------------
// svdw_pkg: shared types and constants for the digit write generator
// Holds the classified item carried between the front and back stages,
// the digit register and code constants, and the per-step multiples.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package svdw_pkg;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned MAG_W   = 17;
  localparam int unsigned REM_W   = 14;
  localparam int unsigned REG_W   = 3;
  localparam int unsigned CODE_W  = 4;

  // Digit register addresses and codes
  localparam logic [REG_W-1:0]  REG_FIRST  = 3'd4;
  localparam logic [REG_W-1:0]  REG_LAST   = 3'd1;
  localparam logic [CODE_W-1:0] MINUS_CODE = 4'd10;

  // Sequencer step: 0 = thousands, 3 = units
  typedef logic [1:0] step_t;
  localparam step_t STEP_FIRST = 2'd0;
  localparam step_t STEP_LAST  = 2'd3;

  // Classified request: sign and magnitude modulo 10000
  typedef struct packed {
    logic             neg;
    logic [REM_W-1:0] rem;
  } item_t;

  // j times the weight of the digit handled at step s
  function automatic logic [REM_W-1:0] step_multiple(step_t s, logic [CODE_W-1:0] j);
    logic [REM_W-1:0] jw;
    jw = REM_W'(j);
    case (s)
      2'd0:    return REM_W'(jw * 14'd1000);
      2'd1:    return REM_W'(jw * 14'd100);
      2'd2:    return REM_W'(jw * 14'd10);
      default: return jw;
    endcase
  endfunction

endpackage

@@ rtl/svdw_front.sv @@
// ---------------------------------------------------------------------------
// svdw_front: request intake and classification
// Registers the sign and the magnitude modulo 10000 of each accepted value
// and hands the result to the queue as soon as it has room.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module svdw_front import svdw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [VALUE_W-1:0] signed_value_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output item_t              q_item_o
);

  logic             valid_q, valid_d;
  item_t            item_q;
  logic             accept;
  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] rem_wide;
  item_t            item_d;

  assign full_o   = valid_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_push_o = valid_q && !q_full_i;
  assign q_item_o = item_q;

  // Magnitude, then fold it below 10000 with three compares
  always_comb begin
    mag = signed_value_i[VALUE_W-1]
        ? (17'h10000 - {1'b0, signed_value_i})
        : {1'b0, signed_value_i};
    if (mag >= 17'd30000) begin
      rem_wide = mag - 17'd30000;
    end else if (mag >= 17'd20000) begin
      rem_wide = mag - 17'd20000;
    end else if (mag >= 17'd10000) begin
      rem_wide = mag - 17'd10000;
    end else begin
      rem_wide = mag;
    end
    item_d.neg = signed_value_i[VALUE_W-1];
    item_d.rem = rem_wide[REM_W-1:0];
  end

  // Stage valid: set on accept, cleared once the queue takes it
  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (q_push_o) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

@@ rtl/svdw_fifo.sv @@
// ---------------------------------------------------------------------------
// svdw_fifo: short queue of classified requests
// Decouples the front stage from the digit sequencer; push and pop may
// happen in the same cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module svdw_fifo import svdw_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_MAX);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ rtl/svdw_back.sv @@
// ---------------------------------------------------------------------------
// svdw_back: digit sequencer and output register
// Walks the head request through four steps, thousands down to units,
// producing one digit write per step into a single output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module svdw_back import svdw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  item_t             q_item_i,
  output logic              q_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [REG_W-1:0]  digit_register_o,
  output logic [CODE_W-1:0] digit_code_o,
  output logic              last_of_run_o
);

  step_t             step_q, step_d;
  logic [REM_W-1:0]  rem_q;
  logic              out_valid_q, out_valid_d;
  logic [REG_W-1:0]  reg_q;
  logic [CODE_W-1:0] code_q;
  logic              last_q;

  logic              fire;
  logic [REM_W-1:0]  src;
  logic [REM_W-1:0]  sub;
  logic [REM_W-1:0]  mult;
  logic [CODE_W-1:0] digit;
  logic [CODE_W-1:0] code_d;

  assign empty_o          = !out_valid_q;
  assign digit_register_o = reg_q;
  assign digit_code_o     = code_q;
  assign last_of_run_o    = last_q;

  assign fire    = q_valid_i && (!out_valid_q || pop_i);
  assign q_pop_o = fire && (step_q == STEP_LAST);

  // Digit at this step: count of multiples of its weight not above the remainder
  always_comb begin
    src   = (step_q == STEP_FIRST) ? q_item_i.rem : rem_q;
    digit = '0;
    sub   = '0;
    mult  = '0;
    for (int j = 1; j <= 9; j++) begin
      mult = step_multiple(step_q, CODE_W'(j));
      if (src >= mult) begin
        digit = CODE_W'(j);
        sub   = mult;
      end
    end
    code_d = (step_q == STEP_FIRST && q_item_i.neg) ? MINUS_CODE : digit;
  end

  // Sequencer and output valid next state
  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (fire) begin
      step_d      = step_q + 1'b1;
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Running remainder and output payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      rem_q  <= src - sub;
      reg_q  <= REG_FIRST - REG_W'(step_q);
      code_q <= code_d;
      last_q <= (step_q == STEP_LAST);
    end
  end

endmodule

@@ rtl/signed_value_to_digit_writes.sv @@
// ---------------------------------------------------------------------------
// signed_value_to_digit_writes: signed value to 4-digit display writes
// Turns each signed 16-bit value into four digit register writes.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: drive signed_value_i and push; a request is taken at a
//   clock edge with push high and full low.
//   Result channel: while empty is low the oldest write is on
//   digit_register_o, digit_code_o and last_of_run_o; pop takes it.
//   Each request gives writes to registers 4, 3, 2, 1 in that order; the
//   write to register 1 has last_of_run_o set. Register 4 carries the minus
//   code (10) for negative values, else the thousands digit.
// Path: a request passes the intake register, the queue and the output
//   register before its first write shows on the result ports.
// Throughput: the digit sequencer retires one digit per cycle into the
//   output register while pop is high; new requests queue meanwhile.
// Stalls: with pop low the output register holds, the sequencer stops,
//   and the request queue plus the intake stage fill before full rises.
// Reset: rst_ni clears all valid state; the block comes up empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_value_to_digit_writes import svdw_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [VALUE_W-1:0] signed_value_i,
  output logic               empty,
  input  logic               pop,
  output logic [REG_W-1:0]   digit_register_o,
  output logic [CODE_W-1:0]  digit_code_o,
  output logic               last_of_run_o
);

  logic  q_push, q_full, q_pop, q_valid;
  item_t fr_item, q_item;

  // Intake and classification
  svdw_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .signed_value_i (signed_value_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_item_o       (fr_item)
  );

  // Decoupling queue
  svdw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (fr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // Digit sequencer
  svdw_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_pop_o          (q_pop),
    .empty_o          (empty),
    .pop_i            (pop),
    .digit_register_o (digit_register_o),
    .digit_code_o     (digit_code_o),
    .last_of_run_o    (last_of_run_o)
  );

  // Last write always targets the units register
  a_last_is_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && last_of_run_o |-> digit_register_o == REG_LAST)
    else $error("last_of_run on a write not to the units register");

  // Minus code only in the leftmost register
  a_minus_leftmost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && digit_code_o == MINUS_CODE |-> digit_register_o == REG_FIRST)
    else $error("minus code outside the leftmost register");

  // A new run starts at the leftmost register
  a_run_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && last_of_run_o ##1 !empty |-> digit_register_o == REG_FIRST)
    else $error("run did not restart at the leftmost register");

  // Within a run registers count down by one
  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && !last_of_run_o ##1 !empty
      |-> digit_register_o == REG_W'($past(digit_register_o) - 3'd1))
    else $error("digit registers out of order within a run");

endmodule

@@ test/signed_value_to_digit_writes_tb.sv @@
// ---------------------------------------------------------------------------
// signed_value_to_digit_writes_tb: self-checking bench for the digit writer
// Pushes signed 16-bit values through the queue-style input, predicts the
// four digit register writes per value, and checks every popped write in
// order. Runs a directed set of edge values, then random values under
// several idle and stall mixes on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_value_to_digit_writes_tb;
  import svdw_pkg::*;

  // Display register addresses, leftmost to units
  localparam logic [REG_W-1:0] REG_THOUSANDS = REG_FIRST;
  localparam logic [REG_W-1:0] REG_HUNDREDS  = 3'd3;
  localparam logic [REG_W-1:0] REG_TENS      = 3'd2;
  localparam logic [REG_W-1:0] REG_UNITS     = REG_LAST;

  localparam int unsigned RANDOM_PER_PHASE = 125;
  localparam int unsigned DRAIN_LIMIT      = 50000;

  typedef struct {
    logic [REG_W-1:0]  addr;
    logic [CODE_W-1:0] code;
    logic              last;
  } digit_write_t;

  // Expected display writes, oldest first, and the mismatch tally
  class digit_write_book;
    digit_write_t pending_writes[$];
    int unsigned  write_errors;

    function void add_write(logic [REG_W-1:0] addr, logic [CODE_W-1:0] code,
                            logic last);
      digit_write_t w;
      w.addr = addr;
      w.code = code;
      w.last = last;
      pending_writes.push_back(w);
    endfunction

    // Accepted value: sign or thousands digit, then hundreds, tens, units
    function void note_value(logic [VALUE_W-1:0] value);
      logic              neg;
      logic [MAG_W-1:0]  mag;
      logic [CODE_W-1:0] lead;
      neg  = value[VALUE_W-1];
      mag  = neg ? (MAG_W'(17'h10000) - MAG_W'(value)) : MAG_W'(value);
      lead = neg ? MINUS_CODE : CODE_W'((mag % 17'd10000) / 17'd1000);
      add_write(REG_THOUSANDS, lead, 1'b0);
      add_write(REG_HUNDREDS, CODE_W'((mag % 17'd1000) / 17'd100), 1'b0);
      add_write(REG_TENS, CODE_W'((mag % 17'd100) / 17'd10), 1'b0);
      add_write(REG_UNITS, CODE_W'(mag % 17'd10), 1'b1);
    endfunction

    // Popped write against the oldest expectation
    function void check_write(logic [REG_W-1:0] addr, logic [CODE_W-1:0] code,
                              logic last);
      digit_write_t w;
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write: expected none, actual reg %0d code %0d last %0b",
                 $time, addr, code, last);
        write_errors++;
        return;
      end
      w = pending_writes.pop_front();
      if (addr !== w.addr) begin
        $display("%0t: digit_register mismatch: expected %0d actual %0d",
                 $time, w.addr, addr);
        write_errors++;
      end
      if (code !== w.code) begin
        $display("%0t: digit_code mismatch: expected %0d actual %0d",
                 $time, w.code, code);
        write_errors++;
      end
      if (last !== w.last) begin
        $display("%0t: last_of_run mismatch: expected %0b actual %0b",
                 $time, w.last, last);
        write_errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic [VALUE_W-1:0] signed_value_i;
  logic               empty;
  logic               pop;
  logic [REG_W-1:0]   digit_register_o;
  logic [CODE_W-1:0]  digit_code_o;
  logic               last_of_run_o;

  digit_write_book board;
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;

  signed_value_to_digit_writes uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .signed_value_i   (signed_value_i),
    .empty            (empty),
    .pop              (pop),
    .digit_register_o (digit_register_o),
    .digit_code_o     (digit_code_o),
    .last_of_run_o    (last_of_run_o)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Push one value; waits for the request to be taken
  task automatic send_value(logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      push = 1'b0;
    end
    @(negedge clk_i);
    push           = 1'b1;
    signed_value_i = value;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    board.note_value(value);
  endtask

  // Half small magnitudes so every digit is exercised, half full-range
  function automatic logic [VALUE_W-1:0] pick_value();
    int v;
    case ($urandom_range(3))
      0: v = $urandom_range(65535);
      1: v = $urandom_range(9999);
      2: v = -int'($urandom_range(9999));
      default: v = int'($urandom_range(65535)) - 32768;
    endcase
    return VALUE_W'(v);
  endfunction

  // Result side: random pop, check on each taken write
  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      pop = ($urandom_range(99) >= recv_stall_pct);
      @(posedge clk_i);
      if (pop && !empty)
        board.check_write(digit_register_o, digit_code_o, last_of_run_o);
    end
  end

  // Stimulus and end of run
  initial begin
    int directed[$];
    int unsigned guard;
    board          = new();
    push           = 1'b0;
    signed_value_i = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Edge values: digit boundaries, range ends, most negative value,
    // dropped high digits, alternating bit patterns
    directed = '{0, 1, -1, 9, 10, 99, 100, 999, 1000, 9999, 10000, 32767,
                 -32767, -32768, -9999, -10000, 1234, -5678, 12345, -12345,
                 21845, -21846, 20009, -909};
    foreach (directed[i]) send_value(VALUE_W'(directed[i]));

    // Random phases: free flow, slow sender, slow receiver, both idling
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      repeat (RANDOM_PER_PHASE) send_value(pick_value());
    end
    @(negedge clk_i);
    push = 1'b0;

    // Drain, then keep clocking to catch stray writes
    guard = 0;
    while (board.pending_writes.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (16) @(posedge clk_i);
    if (board.pending_writes.size() != 0) begin
      $display("%0t: %0d expected writes never arrived", $time,
               board.pending_writes.size());
      board.write_errors++;
    end
    if (board.write_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/svdw_pkg.sv
rtl/svdw_front.sv
rtl/svdw_fifo.sv
rtl/svdw_back.sv
rtl/signed_value_to_digit_writes.sv
test/signed_value_to_digit_writes_tb.sv
